// File: design/dtq_pkg.sv
package dtq_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 32;
  localparam logic [10:0] MAX_PACKETS_RESET = 11'd1000;

  localparam logic [3:0] REQ_ENQUEUE     = 4'd0;
  localparam logic [3:0] REQ_DEQUEUE     = 4'd1;
  localparam logic [3:0] REQ_PEEK        = 4'd2;
  localparam logic [3:0] REQ_PUSH_FRONT  = 4'd3;
  localparam logic [3:0] REQ_FLUSH       = 4'd4;
  localparam logic [3:0] REQ_RESET_STATS = 4'd5;
  localparam logic [3:0] REQ_RESET_SHORT = 4'd6;
  localparam logic [3:0] REQ_COUNT_SMALL = 4'd7;
  localparam logic [3:0] REQ_READ_CNT    = 4'd8;

  localparam logic [2:0] SEL_RX_BYTES   = 3'd0;
  localparam logic [2:0] SEL_RX_PKTS    = 3'd1;
  localparam logic [2:0] SEL_DROP_BYTES = 3'd2;
  localparam logic [2:0] SEL_DROP_PKTS  = 3'd3;
  localparam logic [2:0] SEL_ENQ_VOL    = 3'd4;
  localparam logic [2:0] SEL_DEQ_VOL    = 3'd5;

  localparam logic CFG_MAX_PACKETS = 1'b0;
  localparam logic CFG_FLOW_ID     = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_FIRST = 2'd1;
  localparam logic [1:0] EV_BUF   = 2'd2;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: design/dtq_ram.sv
module dtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/dtq_ctrl.sv
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_req_type,
  input  logic [15:0]         in_pkt_handle,
  input  logic [15:0]         in_pkt_size,
  input  logic [15:0]         in_size_limit,
  input  logic [2:0]          in_counter_select,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output mem_req_t            mem_req,
  input  logic [ENTRY_W-1:0]  mem_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic                out_item_valid,
  output logic [15:0]         out_item_handle,
  output logic [15:0]         out_item_size,
  output logic [1:0]          out_queue_event,
  output logic [7:0]          out_event_flow,
  output logic [10:0]         out_packet_count,
  output logic [31:0]         out_byte_count,
  output logic [31:0]         out_query_value
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_OUT} state_t;

  state_t state_r;
  logic [IDX_W-1:0] head_r;
  logic [OCC_W-1:0] occ_r, scan_r;
  logic [31:0] held_r, rxb_r, rxp_r, drb_r, drp_r, enq_r, deq_r;
  logic [10:0] maxp_r;
  logic [7:0] flow_r;
  logic [3:0] req_r;
  logic [15:0] limit_r;
  logic [31:0] query_r;

  logic in_fire, full, drop;
  logic [OCC_W-1:0] tail_off;
  logic [IDX_W-1:0] tail_idx, scan_idx;
  logic [15:0] rd_size;

  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign full = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign drop = ({{(OCC_W > 11 ? OCC_W - 11 : 1){1'b0}}, maxp_r} <= {1'b0, occ_r}) || full;
  assign tail_off = occ_r;
  assign tail_idx = head_r + tail_off[IDX_W-1:0];
  assign scan_idx = head_r + scan_r[IDX_W-1:0];
  assign rd_size = mem_rdata[15:0];

  always_comb begin
    mem_req = '0;
    mem_req.wdata = {in_pkt_handle, in_pkt_size};
    if (in_fire && in_req_type == REQ_ENQUEUE && !drop) begin
      mem_req.we = 1'b1;
      mem_req.waddr = tail_idx;
    end else if (in_fire && in_req_type == REQ_PUSH_FRONT && !full) begin
      mem_req.we = 1'b1;
      mem_req.waddr = head_r - IDX_W'(1);
    end
    if (in_fire) begin
      mem_req.re = 1'b1;
      mem_req.raddr = head_r;
    end else if (state_r == S_SCAN) begin
      mem_req.re = 1'b1;
      mem_req.raddr = scan_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      head_r <= '0; occ_r <= '0; held_r <= '0;
      rxb_r <= '0; rxp_r <= '0; drb_r <= '0; drp_r <= '0;
      enq_r <= '0; deq_r <= '0;
      maxp_r <= MAX_PACKETS_RESET; flow_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_MAX_PACKETS) maxp_r <= cfg_data[10:0];
        else flow_r <= cfg_data[7:0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_fire) begin
          req_r <= in_req_type;
          limit_r <= in_size_limit;
          out_accepted <= 1'b1;
          out_item_valid <= 1'b0;
          out_item_handle <= '0;
          out_item_size <= '0;
          out_queue_event <= EV_NONE;
          out_event_flow <= '0;
          out_query_value <= '0;
          state_r <= S_OUT;
          case (in_req_type)
            REQ_ENQUEUE: begin
              if (drop) begin
                out_accepted <= 1'b0;
                drp_r <= drp_r + 32'd1;
                drb_r <= drb_r + 32'(in_pkt_size);
              end else begin
                out_queue_event <= (occ_r == '0) ? EV_FIRST : EV_BUF;
                out_event_flow <= flow_r;
                occ_r <= occ_r + OCC_W'(1);
                held_r <= held_r + 32'(in_pkt_size);
                rxb_r <= rxb_r + 32'(in_pkt_size);
                rxp_r <= rxp_r + 32'd1;
                enq_r <= enq_r + 32'(in_pkt_size);
              end
            end
            REQ_DEQUEUE, REQ_PEEK: if (occ_r != '0) state_r <= S_READ;
            REQ_PUSH_FRONT: begin
              if (full) out_accepted <= 1'b0;
              else begin
                head_r <= head_r - IDX_W'(1);
                occ_r <= occ_r + OCC_W'(1);
                held_r <= held_r + 32'(in_pkt_size);
                deq_r <= deq_r - 32'(in_pkt_size);
              end
            end
            REQ_FLUSH: begin
              deq_r <= deq_r + held_r;
              occ_r <= '0;
              held_r <= '0;
            end
            REQ_RESET_STATS: begin
              rxb_r <= '0; rxp_r <= '0; drb_r <= '0; drp_r <= '0;
            end
            REQ_RESET_SHORT: begin
              enq_r <= '0; deq_r <= '0;
            end
            REQ_COUNT_SMALL: begin
              scan_r <= '0;
              query_r <= '0;
              if (occ_r != '0) state_r <= S_SCAN;
            end
            REQ_READ_CNT: begin
              case (in_counter_select)
                SEL_RX_BYTES:   out_query_value <= rxb_r;
                SEL_RX_PKTS:    out_query_value <= rxp_r;
                SEL_DROP_BYTES: out_query_value <= drb_r;
                SEL_DROP_PKTS:  out_query_value <= drp_r;
                SEL_ENQ_VOL:    out_query_value <= enq_r;
                SEL_DEQ_VOL:    out_query_value <= deq_r;
                default:        out_query_value <= '0;
              endcase
            end
            default: ;
          endcase
          if (!(in_req_type == REQ_DEQUEUE || in_req_type == REQ_PEEK ||
                in_req_type == REQ_COUNT_SMALL) ||
              occ_r == '0) begin
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_READ: begin
          out_item_valid <= 1'b1;
          out_item_handle <= mem_rdata[31:16];
          out_item_size <= rd_size;
          if (req_r == REQ_DEQUEUE) begin
            head_r <= head_r + IDX_W'(1);
            occ_r <= occ_r - OCC_W'(1);
            held_r <= held_r - 32'(rd_size);
            deq_r <= deq_r + 32'(rd_size);
          end
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (rd_size > limit_r || scan_r + OCC_W'(1) == occ_r) begin
            out_query_value <= (rd_size > limit_r) ? query_r : query_r + 32'd1;
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            query_r <= query_r + 32'd1;
            scan_r <= scan_r + OCC_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_packet_count = 11'(occ_r);
  assign out_byte_count = held_r;

endmodule

// File: design/drop_tail_packet_queue_stats.sv
// most requests are answered straight from the idle state; dequeue and peek of a held packet
// first read the head entry (S_READ), and count_smaller scans the leading packets in S_SCAN
// a new request is accepted only after the previous result is taken
// reset: synchronous active-low rst_n clears counters, occupancy and head;
// queue storage is not cleared, max_packets returns to 1000, flow_id to 0
module drop_tail_packet_queue_stats
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_req_type,
  input  logic [15:0] in_pkt_handle,
  input  logic [15:0] in_pkt_size,
  input  logic [15:0] in_size_limit,
  input  logic [2:0]  in_counter_select,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_item_valid,
  output logic [15:0] out_item_handle,
  output logic [15:0] out_item_size,
  output logic [1:0]  out_queue_event,
  output logic [7:0]  out_event_flow,
  output logic [10:0] out_packet_count,
  output logic [31:0] out_byte_count,
  output logic [31:0] out_query_value
);

  mem_req_t mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  dtq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(mem_req.we), .waddr(mem_req.waddr), .wdata(mem_req.wdata),
    .re(mem_req.re), .raddr(mem_req.raddr), .rdata(mem_rdata)
  );

  dtq_ctrl u_ctrl (.*);

endmodule

// File: design/dtq_checker.sv
module dtq_checker
  import dtq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_item_valid,
  input logic [1:0]  out_queue_event,
  input logic [7:0]  out_event_flow,
  input logic [10:0] out_packet_count
);

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  a_event_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_event != EV_NONE |-> out_accepted && !out_item_valid)
    else $error("event without stored packet");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_event == EV_FIRST |-> out_packet_count == 11'd1)
    else $error("first-buffered event with wrong count");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packet_count))
    else $error("result dropped while stalled");

endmodule

bind drop_tail_packet_queue_stats dtq_checker u_chk (.*);
